// ===== rtl/core/necd_pkg.sv =====
// necd_pkg: shared types, constants and helper functions for the NEC IR frame decoder.
// Used by every file under rtl/core; has no dependencies of its own.
package necd_pkg;

    // Width of the interval length field, in microseconds
    localparam int DURATION_BITS = 20;
    localparam int TOL_W         = 10;
    localparam int STATUS_W      = 3;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 16;
    localparam int COUNT_W       = 5;
    localparam int USER_IN_W     = 2;
    localparam int DATA_IN_W     = ((DURATION_BITS + 7) / 8) * 8;
    localparam int DATA_OUT_W    = ((STATUS_W + 2 * BYTE_W + 7) / 8) * 8;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100);

    // Nominal timings in microseconds
    localparam int unsigned NOM_LEAD_SPACE = 9000;
    localparam int unsigned NOM_LEAD_PULSE = 4500;
    localparam int unsigned NOM_BIT_ZERO   = 563;
    localparam int unsigned NOM_BIT_ONE    = 1687;
    localparam int unsigned NOM_REP_PULSE  = 2300;
    localparam int unsigned NOM_REP_SPACE  = 540;
    localparam int unsigned REP_GAP_LOW    = 37000;
    localparam int unsigned REP_GAP_HIGH   = 110000;
    localparam logic [BYTE_W-1:0] INV_CHECK = 8'hff;

    localparam logic MODE_DECODE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;
    localparam logic FORM_SPACE   = 1'b0;
    localparam logic FORM_PULSE   = 1'b1;

    typedef enum logic [3:0] {
        PH_READY,
        PH_LEAD1,
        PH_ADDR,
        PH_CMD,
        PH_WAITREP,
        PH_REP1,
        PH_REP2,
        PH_REP3,
        PH_REP4,
        PH_FAILED
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_MORE     = 3'd0,
        ST_MORE_REP = 3'd1,
        ST_MSG      = 3'd2,
        ST_REP      = 3'd3,
        ST_FAIL     = 3'd4
    } t_status;

    // One classified interval, as handed from the front end to the sequencer
    typedef struct packed {
        logic restart;
        logic pulse;
        logic near_lead_space;
        logic near_lead_pulse;
        logic near_one;
        logic near_zero;
        logic near_rep_pulse;
        logic near_rep_space;
        logic rep_gap;
    } t_class;

    // Strict absolute tolerance match: |d - nominal| < tol
    function automatic logic near_to(input logic [DURATION_BITS-1:0] d,
                                     input int unsigned nominal,
                                     input logic [TOL_W-1:0] tol);
        logic [DURATION_BITS-1:0] nom;
        logic [DURATION_BITS-1:0] diff;
        nom  = DURATION_BITS'(nominal);
        diff = (d > nom) ? (d - nom) : (nom - d);
        return diff < {{(DURATION_BITS - TOL_W){1'b0}}, tol};
    endfunction

    // A word is valid when its high byte is the inverse of its low byte
    function automatic logic word_ok(input logic [WORD_W-1:0] w);
        return (w[BYTE_W-1:0] ^ w[WORD_W-1:BYTE_W]) == INV_CHECK;
    endfunction

endpackage

// ===== rtl/core/necd_front.sv =====
// necd_front: holds the tolerance register and classifies each incoming interval.
// Depends on necd_pkg.
module necd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [necd_pkg::TOL_W-1:0]        i_cfg_data,
    input  logic                              i_mode,
    input  logic                              i_form,
    input  logic [necd_pkg::DURATION_BITS-1:0] i_duration,
    output necd_pkg::t_class                  o_class
);
    import necd_pkg::*;

    logic [TOL_W-1:0] r_tolerance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tolerance <= i_cfg_data;
        end
    end

    // All compares run in parallel; none depends on decoder state.
    always_comb begin
        o_class.restart         = (i_mode == MODE_RESTART);
        o_class.pulse           = (i_form == FORM_PULSE);
        o_class.near_lead_space = near_to(i_duration, NOM_LEAD_SPACE, r_tolerance);
        o_class.near_lead_pulse = near_to(i_duration, NOM_LEAD_PULSE, r_tolerance);
        o_class.near_one        = near_to(i_duration, NOM_BIT_ONE, r_tolerance);
        o_class.near_zero       = near_to(i_duration, NOM_BIT_ZERO, r_tolerance);
        o_class.near_rep_pulse  = near_to(i_duration, NOM_REP_PULSE, r_tolerance);
        o_class.near_rep_space  = near_to(i_duration, NOM_REP_SPACE, r_tolerance);
        o_class.rep_gap         = (i_duration > DURATION_BITS'(REP_GAP_LOW)) &&
                                  (i_duration < DURATION_BITS'(REP_GAP_HIGH));
    end

endmodule

// ===== rtl/core/necd_queue.sv =====
// necd_queue: short first-in first-out buffer of classified intervals.
// Depends on necd_pkg.
module necd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  necd_pkg::t_class i_item,
    output logic             o_full,
    output logic             o_valid,
    output necd_pkg::t_class o_item,
    input  logic             i_pop
);
    import necd_pkg::*;

    t_class               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/necd_back.sv =====
// necd_back: frame sequencer that walks the NEC phases and holds the result register.
// Depends on necd_pkg.
module necd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  necd_pkg::t_class              i_q_item,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [necd_pkg::DATA_OUT_W-1:0] o_data
);
    import necd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [COUNT_W-1:0]  r_bit_count, n_bit_count;
    logic                r_half, n_half;
    logic [WORD_W-1:0]   r_addr_word, n_addr_word;
    logic [WORD_W-1:0]   r_cmd_word, n_cmd_word;
    logic [BYTE_W-1:0]   r_addr_latch, n_addr_latch;
    logic [BYTE_W-1:0]   r_cmd_latch, n_cmd_latch;
    t_status             n_status;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [BYTE_W-1:0]   r_out_addr;
    logic [BYTE_W-1:0]   r_out_cmd;

    // Half-bit step shared by the address and command phases
    logic [WORD_W-1:0]   tb_word;
    logic [COUNT_W-1:0]  tb_count;
    logic                tb_half;
    logic                tb_fail;
    logic                tb_full;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = {{(DATA_OUT_W - STATUS_W - 2 * BYTE_W){1'b0}},
                      r_out_cmd, r_out_addr, r_out_status};

    always_comb begin
        tb_word  = (r_phase == PH_CMD) ? r_cmd_word : r_addr_word;
        tb_count = r_bit_count;
        tb_half  = r_half;
        tb_fail  = 1'b0;
        tb_full  = 1'b0;
        if (r_bit_count[COUNT_W-1]) begin
            tb_fail = 1'b1;
        end else if (!i_q_item.pulse && !r_half) begin
            tb_half = 1'b1;
        end else if (i_q_item.pulse && r_half) begin
            tb_half = 1'b0;
            if (i_q_item.near_one) begin
                tb_word[r_bit_count[COUNT_W-2:0]] = 1'b1;
            end else if (i_q_item.near_zero) begin
                tb_word[r_bit_count[COUNT_W-2:0]] = 1'b0;
            end else begin
                tb_fail = 1'b1;
            end
            if (!tb_fail) begin
                tb_count = r_bit_count + 1'b1;
                tb_full  = (tb_count == COUNT_W'(WORD_W));
            end
        end else begin
            tb_fail = 1'b1;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_half       = r_half;
        n_addr_word  = r_addr_word;
        n_cmd_word   = r_cmd_word;
        n_addr_latch = r_addr_latch;
        n_cmd_latch  = r_cmd_latch;
        n_status     = ST_FAIL;
        if (i_q_item.restart) begin
            n_phase     = PH_READY;
            n_bit_count = '0;
            n_half      = 1'b0;
            n_addr_word = '0;
            n_cmd_word  = '0;
            n_status    = ST_MORE;
        end else begin
            case (r_phase)
                PH_READY: begin
                    if (r_bit_count == '0 && !i_q_item.pulse && i_q_item.near_lead_space) begin
                        n_phase  = PH_LEAD1;
                        n_status = ST_MORE;
                    end
                end
                PH_LEAD1: begin
                    if (r_bit_count == '0 && i_q_item.pulse && i_q_item.near_lead_pulse) begin
                        n_phase  = PH_ADDR;
                        n_half   = 1'b0;
                        n_status = ST_MORE;
                    end
                end
                PH_ADDR: begin
                    if (!tb_fail) begin
                        n_half      = tb_half;
                        n_addr_word = tb_word;
                        n_bit_count = tb_count;
                        if (!tb_full) begin
                            n_status = ST_MORE;
                        end else if (word_ok(tb_word)) begin
                            n_phase      = PH_CMD;
                            n_bit_count  = '0;
                            n_addr_latch = tb_word[BYTE_W-1:0];
                            n_status     = ST_MORE;
                        end
                    end
                end
                PH_CMD: begin
                    if (!tb_fail) begin
                        n_half      = tb_half;
                        n_cmd_word  = tb_word;
                        n_bit_count = tb_count;
                        if (!tb_full) begin
                            n_status = ST_MORE;
                        end else if (word_ok(tb_word)) begin
                            n_phase     = PH_WAITREP;
                            n_bit_count = '0;
                            n_cmd_latch = tb_word[BYTE_W-1:0];
                            n_status    = ST_MSG;
                        end
                    end
                end
                PH_WAITREP: begin
                    if (!i_q_item.pulse && i_q_item.near_zero) begin
                        n_phase  = PH_REP1;
                        n_status = ST_MORE_REP;
                    end
                end
                PH_REP1: begin
                    if (i_q_item.pulse && i_q_item.rep_gap) begin
                        n_phase  = PH_REP2;
                        n_status = ST_MORE_REP;
                    end
                end
                PH_REP2: begin
                    if (!i_q_item.pulse && i_q_item.near_lead_space) begin
                        n_phase  = PH_REP3;
                        n_status = ST_MORE_REP;
                    end
                end
                PH_REP3: begin
                    if (i_q_item.pulse && i_q_item.near_rep_pulse) begin
                        n_phase  = PH_REP4;
                        n_status = ST_MORE_REP;
                    end
                end
                PH_REP4: begin
                    if (!i_q_item.pulse && i_q_item.near_rep_space) begin
                        n_phase  = PH_REP1;
                        n_status = ST_REP;
                    end
                end
                default: begin
                    n_status = ST_FAIL;
                end
            endcase
            // Any mismatch parks the sequencer until a restart arrives
            if (n_status == ST_FAIL) begin
                n_phase = PH_FAILED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_READY;
            r_bit_count  <= '0;
            r_half       <= 1'b0;
            r_addr_word  <= '0;
            r_cmd_word   <= '0;
            r_addr_latch <= '0;
            r_cmd_latch  <= '0;
        end else if (o_q_pop) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_half       <= n_half;
            r_addr_word  <= n_addr_word;
            r_cmd_word   <= n_cmd_word;
            r_addr_latch <= n_addr_latch;
            r_cmd_latch  <= n_cmd_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_status <= n_status;
            r_out_addr   <= n_addr_latch;
            r_out_cmd    <= n_cmd_latch;
        end
    end

endmodule

// ===== rtl/core/nec_ir_frame_decoder.sv =====
// nec_ir_frame_decoder: top level of the NEC infrared frame decoder.
// Depends on necd_pkg, necd_front, necd_queue and necd_back.
//
// The decoder takes timed line intervals (a space or a pulse with a length in
// microseconds) and recognises the NEC leader, the 32 pulse-distance bits that
// carry the address and command words with their inverses, and the repeat-code
// chain that follows a message. Every input beat yields exactly one output beat
// whose status reads need more, need more to repeat, message decoded, repeat
// decoded or failed, together with the low bytes of the last accepted address
// and command words. Failure is sticky until a restart beat (mode set) arrives.
// The block sustains one interval per clock cycle: the front end classifies a
// beat against all nominal timings in the cycle it is accepted, a two-entry
// queue holds classified beats, and the sequencer consumes one queued beat per
// cycle into the output register unless a result stalls there. The slave
// side drops tready only when the queue is full, which happens only after
// the master side has stalled. The tolerance register is written through its
// own channel, which is always ready; write it only while no beat is in
// flight.
module nec_ir_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Tolerance register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [necd_pkg::TOL_W-1:0]        i_cfg_data,
    // Interval stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: duration_us, padded with zeros to whole bytes
    input  logic [necd_pkg::DATA_IN_W-1:0]    s_axis_tdata,
    // tuser: mode (bit 0), pulse_form (bit 1)
    input  logic [necd_pkg::USER_IN_W-1:0]    s_axis_tuser,
    // Result stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: status, address_byte, command_byte, then zero padding
    output logic [necd_pkg::DATA_OUT_W-1:0]   m_axis_tdata
);
    import necd_pkg::*;

    t_class  front_class;
    t_class  q_item;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    push;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    necd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (s_axis_tuser[0]),
        .i_form      (s_axis_tuser[1]),
        .i_duration  (s_axis_tdata[DURATION_BITS-1:0]),
        .o_class     (front_class)
    );

    necd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_class),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    necd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

// ===== rtl/core/necd_checker.sv =====
// necd_checker: port-level assertions for nec_ir_frame_decoder, bound to the top level.
// Depends on necd_pkg and nec_ir_frame_decoder.
module necd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [necd_pkg::DATA_OUT_W-1:0]   m_axis_tdata
);
    import necd_pkg::*;

    // Nothing is offered on the result side straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Input back-pressure only arises from a stalled result side
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while no result is pending");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] <= STATUS_W'(ST_FAIL)))
        else $error("undefined status code");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder necd_checker u_necd_checker (.*);

// ===== dv/nec_ir_frame_decoder_checker.sv =====
`timescale 1ns / 100ps
// nec_ir_frame_decoder_checker: watches the tolerance, interval and result channels of the
// decoder, predicts one result beat per accepted interval beat and compares in order.
// Depends on necd_pkg for widths, nominal timings and the phase and status codes.
module nec_ir_frame_decoder_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [necd_pkg::TOL_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // tdata: duration_us, then zero padding
    input  logic [necd_pkg::DATA_IN_W-1:0]    s_axis_tdata,
    // tuser: mode (bit 0), pulse_form (bit 1)
    input  logic [necd_pkg::USER_IN_W-1:0]    s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: status, address_byte, command_byte, then zero padding
    input  logic [necd_pkg::DATA_OUT_W-1:0]   m_axis_tdata,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_msg_count,
    output int                                o_rep_count,
    output int                                o_failed_count
);
    import necd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        HALF_MORE,
        HALF_DONE,
        HALF_BAD
    } t_half;

    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   address;
        logic [BYTE_W-1:0]   command;
    } t_result;

    logic [TOL_W-1:0]   tol_q;
    t_phase             ph;
    logic [COUNT_W-1:0] bit_cnt;
    logic               half_seen;
    logic [WORD_W-1:0]  addr_word;
    logic [WORD_W-1:0]  cmd_word;
    logic [BYTE_W-1:0]  addr_held;
    logic [BYTE_W-1:0]  cmd_held;
    t_result            results_due[$];
    int                 errors;
    int                 msgs;
    int                 reps;
    int                 fails;

    function automatic logic close_to(input logic [DURATION_BITS-1:0] d,
                                      input int unsigned nominal);
        int unsigned gap_us;
        gap_us = (d > nominal) ? d - nominal : nominal - d;
        return gap_us < tol_q;
    endfunction

    function automatic logic word_inverted(input logic [WORD_W-1:0] w);
        return w[WORD_W-1:BYTE_W] == ~w[BYTE_W-1:0];
    endfunction

    // A bit is a space of any length followed by a pulse whose length gives its value;
    // the pulse lands in the word of the current phase, LSB first.
    function automatic t_half take_half(input logic form, input logic [DURATION_BITS-1:0] d);
        logic v;
        if (bit_cnt > 15)
            return HALF_BAD;
        if (form == FORM_SPACE && !half_seen) begin
            half_seen = 1'b1;
            return HALF_MORE;
        end
        if (form == FORM_PULSE && half_seen) begin
            half_seen = 1'b0;
            if (close_to(d, NOM_BIT_ONE))
                v = 1'b1;
            else if (close_to(d, NOM_BIT_ZERO))
                v = 1'b0;
            else
                return HALF_BAD;
            if (ph == PH_ADDR)
                addr_word[bit_cnt[3:0]] = v;
            else
                cmd_word[bit_cnt[3:0]] = v;
            bit_cnt = bit_cnt + 1'b1;
            return (bit_cnt == 16) ? HALF_DONE : HALF_MORE;
        end
        return HALF_BAD;
    endfunction

    function automatic t_status decode_interval(input logic form,
                                                input logic [DURATION_BITS-1:0] d);
        t_half h;
        case (ph)
            PH_READY: begin
                if (bit_cnt == 0 && form == FORM_SPACE && close_to(d, NOM_LEAD_SPACE)) begin
                    ph = PH_LEAD1;
                    return ST_MORE;
                end
            end
            PH_LEAD1: begin
                if (bit_cnt == 0 && form == FORM_PULSE && close_to(d, NOM_LEAD_PULSE)) begin
                    ph = PH_ADDR;
                    half_seen = 1'b0;
                    return ST_MORE;
                end
            end
            PH_ADDR: begin
                h = take_half(form, d);
                if (h == HALF_MORE)
                    return ST_MORE;
                if (h == HALF_DONE && word_inverted(addr_word)) begin
                    ph = PH_CMD;
                    bit_cnt = '0;
                    addr_held = addr_word[BYTE_W-1:0];
                    return ST_MORE;
                end
            end
            PH_CMD: begin
                h = take_half(form, d);
                if (h == HALF_MORE)
                    return ST_MORE;
                if (h == HALF_DONE && word_inverted(cmd_word)) begin
                    ph = PH_WAITREP;
                    bit_cnt = '0;
                    cmd_held = cmd_word[BYTE_W-1:0];
                    return ST_MSG;
                end
            end
            PH_WAITREP: begin
                if (form == FORM_SPACE && close_to(d, NOM_BIT_ZERO)) begin
                    ph = PH_REP1;
                    return ST_MORE_REP;
                end
            end
            PH_REP1: begin
                if (form == FORM_PULSE && d > REP_GAP_LOW && d < REP_GAP_HIGH) begin
                    ph = PH_REP2;
                    return ST_MORE_REP;
                end
            end
            PH_REP2: begin
                if (form == FORM_SPACE && close_to(d, NOM_LEAD_SPACE)) begin
                    ph = PH_REP3;
                    return ST_MORE_REP;
                end
            end
            PH_REP3: begin
                if (form == FORM_PULSE && close_to(d, NOM_REP_PULSE)) begin
                    ph = PH_REP4;
                    return ST_MORE_REP;
                end
            end
            PH_REP4: begin
                if (form == FORM_SPACE && close_to(d, NOM_REP_SPACE)) begin
                    ph = PH_REP1;
                    return ST_REP;
                end
            end
            default: ;
        endcase
        ph = PH_FAILED;
        return ST_FAIL;
    endfunction

    function automatic void clear_frame();
        ph = PH_READY;
        bit_cnt = '0;
        half_seen = 1'b0;
        addr_word = '0;
        cmd_word = '0;
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result due;
        if (!i_rst_n) begin
            tol_q = TOL_RESET;
            clear_frame();
            addr_held = '0;
            cmd_held = '0;
            results_due.delete();
        end else begin
            // Results are compared before the new interval is predicted: a result can
            // never belong to the beat accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status  = t_status'(m_axis_tdata[STATUS_W-1:0]);
                seen.address = m_axis_tdata[STATUS_W +: BYTE_W];
                seen.command = m_axis_tdata[STATUS_W + BYTE_W +: BYTE_W];
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result beat with none due: status %0d addr %02h cmd %02h",
                                 $realtime, seen.status, seen.address, seen.command);
                end else begin
                    due = results_due.pop_front();
                    if (seen != due) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: mismatch: want status %0d addr %02h cmd %02h, got %0d %02h %02h",
                                     $realtime, due.status, due.address, due.command,
                                     seen.status, seen.address, seen.command);
                    end
                    case (seen.status)
                        ST_MSG:  msgs++;
                        ST_REP:  reps++;
                        ST_FAIL: fails++;
                        default: ;
                    endcase
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                tol_q = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == MODE_RESTART) begin
                    clear_frame();
                    due.status = ST_MORE;
                end else begin
                    due.status = decode_interval(s_axis_tuser[1],
                                                 s_axis_tdata[DURATION_BITS-1:0]);
                end
                due.address = addr_held;
                due.command = cmd_held;
                results_due.push_back(due);
            end
        end
        o_fail_count   <= errors;
        o_pending      <= results_due.size();
        o_msg_count    <= msgs;
        o_rep_count    <= reps;
        o_failed_count <= fails;
    end

endmodule

// ===== dv/nec_ir_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// nec_ir_frame_decoder_tb: regression top for the NEC IR frame decoder; drives interval beats
// and tolerance writes, and takes the verdict from nec_ir_frame_decoder_checker.
// Depends on necd_pkg, the decoder RTL and dv/nec_ir_frame_decoder_checker.sv.
module nec_ir_frame_decoder_tb;
    import necd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int NUM_PHASES     = 6;
    localparam int unsigned DUR_MAX = (1 << DURATION_BITS) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [TOL_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata = '0;
    logic [USER_IN_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int msg_count;
    int rep_count;
    int failed_count;

    // Stimulus knobs; tol_now changes only after a drain, the percentages just before one.
    int               idle_pct = 0;
    int               stall_pct = 0;
    logic [TOL_W-1:0] tol_now = TOL_RESET;
    int               beats_sent = 0;
    int               tol_writes = 0;
    int               quiet_cycles = 0;

    nec_ir_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nec_ir_frame_decoder_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_msg_count    (msg_count),
        .o_rep_count    (rep_count),
        .o_failed_count (failed_count)
    );

    always #5 i_clk = ~i_clk;

    // The result side stalls at random according to the current phase; with a zero
    // percentage it is always ready.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any beat on any channel counts as progress. A long run of cycles
    // without one means the decoder has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("nec_ir_frame_decoder regression: fail");
            $finish;
        end
    end

    // Presents one interval beat, after a random number of idle cycles, and returns at
    // the edge where it is taken. tvalid is left high so back-to-back beats need no
    // second assignment in one step.
    task automatic send_interval(input logic mode, input logic form, input int unsigned dur);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        if (dur > DUR_MAX)
            dur = DUR_MAX;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_IN_W'(dur);
        s_axis_tuser  <= {form, mode};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
    endtask

    // Stops sending and waits until every predicted result has come back. The checker's
    // count is registered, so the task lets it update before reading it.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        drain();
        // Every beat gives exactly one result, so the decoder is idle by now; the extra
        // edges are margin.
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tol_now = value;
        tol_writes++;
    endtask

    // A duration that lies within the current tolerance of a nominal value. With a zero
    // tolerance nothing can match, so the nominal value itself is used.
    function automatic int unsigned near_nominal(input int unsigned nominal);
        int span;
        int v;
        span = (tol_now > 0) ? int'(tol_now) - 1 : 0;
        v = int'(nominal) + int'($urandom_range(2 * span)) - span;
        return (v < 0) ? 0 : v;
    endfunction

    function automatic int unsigned noise_duration();
        case ($urandom_range(5))
            0:       return 0;
            1:       return DUR_MAX;
            2:       return $urandom_range(DUR_MAX);
            3:       return $urandom_range(12000);
            4:       return near_nominal($urandom_range(1) ? NOM_BIT_ONE : NOM_LEAD_SPACE);
            default: return $urandom_range(200000);
        endcase
    endfunction

    task automatic send_noise(input int count);
        repeat (count)
            send_interval(($urandom_range(9) == 0) ? MODE_RESTART : MODE_DECODE,
                          1'($urandom_range(1)), noise_duration());
    endtask

    // One part of a frame; with the given chance it is swapped for a noise beat, which
    // breaks the frame at a random place.
    task automatic send_part(input logic form, input int unsigned dur, input int break_pct);
        if ($urandom_range(99) < break_pct)
            send_noise(1);
        else
            send_interval(MODE_DECODE, form, dur);
    endtask

    // The long gap before a repeat code; now and then one of the range's edges, of which
    // only the inner two are accepted.
    function automatic int unsigned repeat_gap();
        if ($urandom_range(9) != 0)
            return $urandom_range(REP_GAP_LOW + 1, REP_GAP_HIGH - 1);
        case ($urandom_range(3))
            0:       return REP_GAP_LOW;
            1:       return REP_GAP_LOW + 1;
            2:       return REP_GAP_HIGH - 1;
            default: return REP_GAP_HIGH;
        endcase
    endfunction

    // A full NEC message with random address and command, usually well formed, followed
    // by a random number of repeat codes.
    task automatic send_frame();
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] cmd;
        logic [WORD_W-1:0] aw;
        logic [WORD_W-1:0] cw;
        logic [2*WORD_W-1:0] bits;
        int break_pct;
        int reps;
        addr = BYTE_W'($urandom_range(255));
        cmd  = BYTE_W'($urandom_range(255));
        aw   = {~addr, addr};
        cw   = {~cmd, cmd};
        // A few words carry a wrong inverse so the word check fails.
        if ($urandom_range(9) == 0)
            aw[WORD_W-1:BYTE_W] ^= BYTE_W'($urandom_range(1, 255));
        if ($urandom_range(9) == 0)
            cw[WORD_W-1:BYTE_W] ^= BYTE_W'($urandom_range(1, 255));
        bits = {cw, aw};
        break_pct = ($urandom_range(9) < 7) ? 0 : 4;
        if ($urandom_range(9) != 0)
            send_interval(MODE_RESTART, 1'($urandom_range(1)), $urandom_range(DUR_MAX));
        send_part(FORM_SPACE, near_nominal(NOM_LEAD_SPACE), break_pct);
        send_part(FORM_PULSE, near_nominal(NOM_LEAD_PULSE), break_pct);
        for (int k = 0; k < 2 * WORD_W; k++) begin
            // The space half of a bit is not timed, so any length will do.
            send_part(FORM_SPACE, $urandom_range(1) ? near_nominal(NOM_BIT_ZERO)
                                                    : $urandom_range(DUR_MAX), break_pct);
            send_part(FORM_PULSE, bits[k] ? near_nominal(NOM_BIT_ONE)
                                          : near_nominal(NOM_BIT_ZERO), break_pct);
        end
        reps = $urandom_range(4);
        if (reps > 0)
            send_part(FORM_SPACE, near_nominal(NOM_BIT_ZERO), break_pct);
        repeat (reps) begin
            send_part(FORM_PULSE, repeat_gap(), break_pct);
            send_part(FORM_SPACE, near_nominal(NOM_LEAD_SPACE), break_pct);
            send_part(FORM_PULSE, near_nominal(NOM_REP_PULSE), break_pct);
            send_part(FORM_SPACE, near_nominal(NOM_REP_SPACE), break_pct);
        end
    endtask

    initial begin
        int target;
        int count;
        logic [TOL_W-1:0] tol_pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset tolerance of 100 us. The first results show the
        // address and command bytes still at zero.
        send_interval(MODE_RESTART, FORM_PULSE, DUR_MAX);
        send_interval(MODE_DECODE, FORM_PULSE, NOM_LEAD_SPACE);     // wrong kind: fails
        send_interval(MODE_DECODE, FORM_SPACE, NOM_LEAD_SPACE);     // failure is sticky
        send_interval(MODE_RESTART, FORM_SPACE, 0);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_LEAD_SPACE + 99);  // just inside
        send_interval(MODE_DECODE, FORM_PULSE, NOM_LEAD_PULSE - 99);
        send_interval(MODE_DECODE, FORM_SPACE, 0);                  // untimed half
        send_interval(MODE_DECODE, FORM_PULSE, NOM_BIT_ONE + 99);
        send_interval(MODE_DECODE, FORM_SPACE, DUR_MAX);
        send_interval(MODE_DECODE, FORM_PULSE, NOM_BIT_ZERO - 99);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_BIT_ZERO);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_BIT_ZERO);       // two spaces: fails
        send_interval(MODE_RESTART, FORM_PULSE, 0);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_LEAD_SPACE + 100); // strict edge fails
        send_interval(MODE_RESTART, FORM_SPACE, DUR_MAX);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_LEAD_SPACE - 99);
        send_interval(MODE_DECODE, FORM_PULSE, NOM_LEAD_PULSE + 99);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_BIT_ZERO);
        send_interval(MODE_DECODE, FORM_PULSE, 1125);               // matches neither value
        send_interval(MODE_DECODE, FORM_SPACE, 0);
        send_interval(MODE_RESTART, FORM_SPACE, 0);
        send_interval(MODE_DECODE, FORM_PULSE, NOM_LEAD_PULSE);     // pulse first: fails

        // With the widest tolerance both bit values match a pulse between them, and a
        // one is taken.
        write_tolerance('1);
        send_interval(MODE_RESTART, FORM_SPACE, 0);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_LEAD_SPACE);
        send_interval(MODE_DECODE, FORM_PULSE, NOM_LEAD_PULSE);
        send_interval(MODE_DECODE, FORM_SPACE, NOM_BIT_ZERO);
        send_interval(MODE_DECODE, FORM_PULSE, 1125);

        // Random part: each phase sets its own tolerance and idling pattern, and is
        // entered only once the decoder has drained.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin tol_pick = TOL_RESET; idle_pct = 0;  stall_pct = 0;  count = 400; end
                1: begin tol_pick = '0;        idle_pct = 47; stall_pct = 0;  count = 100; end
                2: begin tol_pick = '1;        idle_pct = 0;  stall_pct = 47; count = 400; end
                3: begin
                    tol_pick = TOL_W'($urandom_range(1023, 2));
                    idle_pct = 11;
                    stall_pct = 11;
                    count = 400;
                end
                4: begin tol_pick = TOL_W'(1); idle_pct = 47; stall_pct = 0;  count = 300; end
                default: begin
                    tol_pick = TOL_W'($urandom_range(400, 2));
                    idle_pct = 0;
                    stall_pct = 0;
                    count = 400;
                end
            endcase
            // The knobs already apply to the drain before the write; that is harmless.
            write_tolerance(tol_pick);
            target = beats_sent + count;
            while (beats_sent < target) begin
                // Now and then the sender holds back until every result is in.
                if ($urandom_range(19) == 0)
                    drain();
                if ($urandom_range(6) == 0)
                    send_noise($urandom_range(8, 1));
                else
                    send_frame();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d interval beats through %0d tolerance writes, 0 to 1023 us included,",
                 beats_sent, tol_writes);
        $display("with %0d messages, %0d repeat codes and %0d failed statuses seen.",
                 msg_count, rep_count, failed_count);
        if (fail_count == 0 && pending == 0)
            $display("nec_ir_frame_decoder regression: pass");
        else
            $display("nec_ir_frame_decoder regression: fail");
        $finish;
    end

endmodule
